>>> src/pedal_mode_controller_assert.svh
// Assertion macros shared by the pedal mode controller RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef PEDAL_MODE_CONTROLLER_ASSERT_SVH
`define PEDAL_MODE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PMC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error("%m: check failed");
// Consequent must hold in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error("%m: check failed");
`else
`define PMC_ASSERT_SAME(label, ante, cons)
`define PMC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/pmc_pkg.sv
// Package of the pedal mode controller: mode and command codes, item structs,
// configuration defaults. No dependencies.
package pmc_pkg;

	typedef enum logic [2:0] {
		MODE_INITIAL  = 3'd0,
		MODE_MANUAL   = 3'd1,
		MODE_GYRO     = 3'd2,
		MODE_SWEEP    = 3'd3,
		MODE_BIND     = 3'd4,
		MODE_CAL      = 3'd5,
		MODE_CALBIND  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		FP_NONE  = 2'd0,
		FP_LEFT  = 2'd1,
		FP_RIGHT = 2'd2
	} first_pedal_t;

	// Lamp and LED drive codes.
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_HIGH = 2'd1;
	localparam logic [1:0] CMD_LOW  = 2'd2;

	// Radio binding codes.
	localparam logic [1:0] BIND_NONE  = 2'd0;
	localparam logic [1:0] BIND_ENTER = 2'd1;
	localparam logic [1:0] BIND_EXIT  = 2'd2;

	// Angle adjust message codes.
	localparam logic [1:0] ADJ_NONE  = 2'd0;
	localparam logic [1:0] ADJ_ENTER = 2'd1;
	localparam logic [1:0] ADJ_EXIT  = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic REG_SYNC_WINDOW = 1'b0;
	localparam logic REG_SCAN_BLOCK  = 1'b1;
	localparam logic [15:0] SYNC_WINDOW_RESET = 16'd400;
	localparam logic [15:0] SCAN_BLOCK_RESET  = 16'd800;

	localparam int IN_BYTES_W  = 40;
	localparam int OUT_BYTES_W = 24;

	typedef struct packed {
		logic [15:0] sync_window_ms;
		logic [15:0] scan_block_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        buttons_changed;
		logic        long_double_press;
		logic        left_pedal;
		logic        right_pedal;
		logic        calibrate_button;
		logic        bind_button;
		logic        gyro_button;
	} in_item_t;

	typedef struct packed {
		mode_t       mode;
		logic        adjust_sel;
		logic        synchronized;
		logic [1:0]  lamp_cmd;
		logic [1:0]  led_cmd;
		logic [1:0]  bind_cmd;
		logic        servo_stop;
		logic        move_to_entry;
		logic        zero_axis;
		logic        capture_point;
		logic        beep;
		logic [1:0]  adjust_msg;
	} out_item_t;

endpackage

>>> src/pmc_cfg.sv
// Configuration register file of the pedal mode controller (APB-style port).
// Depends on pmc_pkg.
module pmc_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output pmc_pkg::cfg_t cfg
);
	import pmc_pkg::*;

	logic [15:0] sync_window_q;
	logic [15:0] scan_block_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes; the word address is decoded from bit 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_window_q <= SYNC_WINDOW_RESET;
			scan_block_q  <= SCAN_BLOCK_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SYNC_WINDOW: sync_window_q <= pwdata[15:0];
				REG_SCAN_BLOCK:  scan_block_q  <= pwdata[15:0];
				default:         sync_window_q <= sync_window_q;
			endcase
		end
	end

	// Read data follows the address.
	always_comb begin
		unique case (paddr[2])
			REG_SYNC_WINDOW: prdata = {16'd0, sync_window_q};
			REG_SCAN_BLOCK:  prdata = {16'd0, scan_block_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.sync_window_ms = sync_window_q;
	assign cfg.scan_block_ms  = scan_block_q;

endmodule

>>> src/pmc_core.sv
// Mode state registers and the per-sample transition function.
// Depends on pmc_pkg and pedal_mode_controller_assert.svh.
`include "pedal_mode_controller_assert.svh"
module pmc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  pmc_pkg::in_item_t  item,
	input  pmc_pkg::cfg_t      cfg,
	output pmc_pkg::out_item_t res
);
	import pmc_pkg::*;

	mode_t        mode_q, mode_c, mode_n;
	logic         adj_q, adj_n;
	logic         sync_q, sync_n;
	first_pedal_t fp_q, fp_n;
	logic [31:0]  fpt_q, fpt_n;
	logic         chk_q, chk_n;
	logic         blk_q, blk_n;
	logic [31:0]  bst_q, bst_n;
	logic [31:0]  gap;
	logic [31:0]  held;
	logic [1:0]   lamp, led, bcmd, amsg;
	logic         stop, move, zero, cap, beep;
	logic         lp, rp, cal, bnd, gyr;

	assign lp  = item.left_pedal;
	assign rp  = item.right_pedal;
	assign cal = item.calibrate_button;
	assign bnd = item.bind_button;
	assign gyr = item.gyro_button;

	// Next state and commands for the sample in the input register.
	always_comb begin
		mode_c = mode_q;
		mode_n = mode_q;
		adj_n  = adj_q;
		sync_n = sync_q;
		fp_n   = fp_q;
		fpt_n  = fpt_q;
		chk_n  = chk_q;
		blk_n  = blk_q;
		bst_n  = bst_q;
		gap    = '0;
		held   = '0;
		lamp   = CMD_NONE;
		led    = CMD_NONE;
		bcmd   = BIND_NONE;
		amsg   = ADJ_NONE;
		stop   = 1'b0;
		move   = 1'b0;
		zero   = 1'b0;
		cap    = 1'b0;
		beep   = 1'b0;

		// A long double press in scan selects angle adjust.
		if (item.long_double_press && mode_q == MODE_SWEEP) begin
			led   = CMD_HIGH;
			adj_n = 1'b1;
			amsg  = ADJ_ENTER;
		end

		if (item.buttons_changed) begin
			// Track the first pedal down and time the second one.
			if (!chk_q) begin
				if (lp && fp_q == FP_NONE) begin
					fpt_n = item.now_ms;
					fp_n  = FP_LEFT;
				end else if (rp && fp_q == FP_NONE) begin
					fpt_n = item.now_ms;
					fp_n  = FP_RIGHT;
				end
				gap = item.now_ms - fpt_n;
				if ((fp_n == FP_LEFT && rp) || (fp_n == FP_RIGHT && lp)) begin
					sync_n = (gap < {16'd0, cfg.sync_window_ms});
					chk_n  = 1'b1;
				end
			end
			if (!lp && !rp) begin
				fp_n  = FP_NONE;
				fpt_n = '0;
				chk_n = 1'b0;
			end

			// Priority transition chain.
			priority if (cal && bnd) begin
				if (mode_q != MODE_CALBIND) begin
					mode_c = MODE_CALBIND;
					bcmd   = BIND_ENTER;
					lamp   = CMD_LOW;
				end
			end else if (bnd) begin
				if (mode_q != MODE_BIND) begin
					mode_c = MODE_BIND;
					bcmd   = BIND_ENTER;
					lamp   = CMD_LOW;
				end
			end else if (cal) begin
				if (mode_q != MODE_CAL) begin
					mode_c = MODE_CAL;
					lamp   = CMD_LOW;
				end
			end else if ((mode_q == MODE_MANUAL || mode_q == MODE_INITIAL) && gyr) begin
				mode_c = MODE_GYRO;
				lamp   = CMD_HIGH;
				cap    = 1'b1;
			end else if (mode_q == MODE_GYRO && !gyr) begin
				stop   = 1'b1;
				mode_c = MODE_MANUAL;
				lamp   = CMD_LOW;
			end else if (gyr && (mode_q == MODE_CAL || mode_q == MODE_BIND ||
					mode_q == MODE_CALBIND)) begin
				if (mode_q == MODE_BIND || mode_q == MODE_CALBIND) begin
					bcmd = BIND_EXIT;
				end
				mode_c = MODE_GYRO;
				lamp   = CMD_HIGH;
			end else if (mode_q == MODE_INITIAL && (lp || rp)) begin
				mode_c = MODE_MANUAL;
				stop   = 1'b1;
			end else if ((mode_q == MODE_BIND || mode_q == MODE_CAL ||
					mode_q == MODE_CALBIND) && !bnd && !cal && !gyr && !lp && !rp) begin
				if (mode_q == MODE_BIND || mode_q == MODE_CALBIND) begin
					bcmd = BIND_EXIT;
				end
				mode_c = MODE_INITIAL;
			end else begin
				mode_c = mode_q;
			end

			// Scan entry on both pedals, then scan exit once unblocked.
			mode_n = mode_c;
			if ((mode_c == MODE_INITIAL || mode_c == MODE_MANUAL || mode_c == MODE_GYRO) &&
					lp && rp && !blk_q) begin
				mode_n = MODE_SWEEP;
				stop   = 1'b1;
				move   = sync_n;
				blk_n  = 1'b1;
				bst_n  = item.now_ms;
				led    = CMD_LOW;
				beep   = 1'b1;
				zero   = 1'b1;
			end
			if (mode_n == MODE_SWEEP && !blk_n && (lp || rp)) begin
				led    = CMD_LOW;
				adj_n  = 1'b0;
				mode_n = MODE_MANUAL;
				amsg   = ADJ_EXIT;
				stop   = 1'b1;
			end
		end

		// Release the scan block once its time has run out.
		held = item.now_ms - bst_n;
		if (blk_n && held > {16'd0, cfg.scan_block_ms}) begin
			blk_n = 1'b0;
		end
	end

	// State update when the sample moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INITIAL;
			adj_q  <= 1'b0;
			sync_q <= 1'b0;
			fp_q   <= FP_NONE;
			fpt_q  <= '0;
			chk_q  <= 1'b0;
			blk_q  <= 1'b0;
			bst_q  <= '0;
		end else if (adv) begin
			mode_q <= mode_n;
			adj_q  <= adj_n;
			sync_q <= sync_n;
			fp_q   <= fp_n;
			fpt_q  <= fpt_n;
			chk_q  <= chk_n;
			blk_q  <= blk_n;
			bst_q  <= bst_n;
		end
	end

	assign res.mode          = mode_n;
	assign res.adjust_sel    = adj_n;
	assign res.synchronized  = sync_n;
	assign res.lamp_cmd      = lamp;
	assign res.led_cmd       = led;
	assign res.bind_cmd      = bcmd;
	assign res.servo_stop    = stop;
	assign res.move_to_entry = move;
	assign res.zero_axis     = zero;
	assign res.capture_point = cap;
	assign res.beep          = beep;
	assign res.adjust_msg    = amsg;

	// A checked pair always has a first pedal on record.
	`PMC_ASSERT_SAME(a_chk_has_first, chk_q, fp_q != FP_NONE)
	// With no first pedal the stored press time is cleared.
	`PMC_ASSERT_SAME(a_no_first_time_zero, fp_q == FP_NONE, fpt_q == '0)
	// Moving to the entry point only happens on scan entry.
	`PMC_ASSERT_SAME(a_move_on_entry, adv && res.move_to_entry,
		res.mode == MODE_SWEEP && res.servo_stop && res.zero_axis)

endmodule

>>> src/pedal_mode_controller.sv
// Pedal mode controller: input and result register pipeline around the mode state machine.
// Channels: s_tdata samples in, m_tdata results out, APB-style register port.
// Every accepted sample yields exactly one result transaction.
// From the accepting edge the sample sits in the input register while the
// transition function runs, and the result register captures its result once
// the result register is free.
// Throughput is one sample per clock while the receiver does not stall; the
// pmc_core state updates on every advance, so each sample sees all earlier ones.
// When the receiver stalls, the result register holds its transaction and the
// input register keeps at most one more sample; s_tready falls only when both
// are full.
// Reset (arst_n low) clears the mode to initial, all pedal tracking and scan
// block state, and returns sync_window_ms to 400 and scan_block_ms to 800.
// Registers: sync_window_ms at byte address 0, scan_block_ms at byte address 4.
// Registers are to be written only while no sample is in flight.
// Depends on pmc_pkg, pmc_cfg, pmc_core and pedal_mode_controller_assert.svh.
`include "pedal_mode_controller_assert.svh"
module pedal_mode_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata from bit 0: now_ms[31:0], buttons_changed, long_double_press,
	// left_pedal, right_pedal, calibrate_button, bind_button, gyro_button, zero pad.
	input  logic [pmc_pkg::IN_BYTES_W-1:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata from bit 0: mode[2:0], adjust_sel, synchronized, lamp_cmd[1:0],
	// led_cmd[1:0], bind_cmd[1:0], servo_stop, move_to_entry, zero_axis,
	// capture_point, beep, adjust_msg[1:0], zero pad.
	output logic [pmc_pkg::OUT_BYTES_W-1:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pmc_pkg::*;

	cfg_t      cfg;
	in_item_t  in_item;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      s2_free;
	logic      adv;
	logic      take;

	pmc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Unpack the input transaction.
	assign in_item.now_ms            = s_tdata[31:0];
	assign in_item.buttons_changed   = s_tdata[32];
	assign in_item.long_double_press = s_tdata[33];
	assign in_item.left_pedal        = s_tdata[34];
	assign in_item.right_pedal       = s_tdata[35];
	assign in_item.calibrate_button  = s_tdata[36];
	assign in_item.bind_button       = s_tdata[37];
	assign in_item.gyro_button       = s_tdata[38];

	// Handshake between the two pipeline registers.
	assign s2_free  = !valid_s2 || m_tready;
	assign adv      = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign take     = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

	pmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	// Pack the result transaction.
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.adjust_msg, res_s2.beep, res_s2.capture_point,
		res_s2.zero_axis, res_s2.move_to_entry, res_s2.servo_stop, res_s2.bind_cmd,
		res_s2.led_cmd, res_s2.lamp_cmd, res_s2.synchronized, res_s2.adjust_sel,
		res_s2.mode};

	// A waiting sample is never dropped.
	`PMC_ASSERT_NEXT(a_s1_kept, valid_s1 && !adv, valid_s1)
	// Every processed sample shows up as a result transaction.
	`PMC_ASSERT_NEXT(a_result_out, adv, valid_s2)
	// A stalled result transaction stays valid and unchanged.
	`PMC_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
